@@ rtl/core/jtt_pkg.sv @@
// Shared types, constants and TAP next-state function for the TAP state tracker.
package jtt_pkg;

  typedef enum logic [3:0] {
    TAP_RESET = 4'd0,
    TAP_IDLE  = 4'd1,
    TAP_SELDR = 4'd2,
    TAP_CAPDR = 4'd3,
    TAP_SHDR  = 4'd4,
    TAP_EX1DR = 4'd5,
    TAP_PDR   = 4'd6,
    TAP_EX2DR = 4'd7,
    TAP_UPDR  = 4'd8,
    TAP_SELIR = 4'd9,
    TAP_CAPIR = 4'd10,
    TAP_SHIR  = 4'd11,
    TAP_EX1IR = 4'd12,
    TAP_PIR   = 4'd13,
    TAP_EX2IR = 4'd14,
    TAP_UPIR  = 4'd15
  } tap_st_t;

  localparam logic [3:0] MaxBits      = 4'd8;
  localparam logic [7:0] QuirkIrBits  = 8'h17;
  localparam logic [3:0] QuirkIrCount = 4'd5;
  localparam logic [7:0] QuirkDrBits  = 8'h6b;
  localparam logic [3:0] QuirkDrCount = 4'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } jtt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic done;
  } jtt_stat_t;

  function automatic tap_st_t tap_next(input tap_st_t st, input logic tms);
    tap_st_t nxt;
    nxt = TAP_RESET;
    unique case (st)
      TAP_RESET: nxt = tms ? TAP_RESET : TAP_IDLE;
      TAP_IDLE:  nxt = tms ? TAP_SELDR : TAP_IDLE;
      TAP_SELDR: nxt = tms ? TAP_SELIR : TAP_CAPDR;
      TAP_CAPDR: nxt = tms ? TAP_EX1DR : TAP_SHDR;
      TAP_SHDR:  nxt = tms ? TAP_EX1DR : TAP_SHDR;
      TAP_EX1DR: nxt = tms ? TAP_UPDR  : TAP_PDR;
      TAP_PDR:   nxt = tms ? TAP_EX2DR : TAP_PDR;
      TAP_EX2DR: nxt = tms ? TAP_UPDR  : TAP_SHDR;
      TAP_UPDR:  nxt = tms ? TAP_SELDR : TAP_IDLE;
      TAP_SELIR: nxt = tms ? TAP_RESET : TAP_CAPIR;
      TAP_CAPIR: nxt = tms ? TAP_EX1IR : TAP_SHIR;
      TAP_SHIR:  nxt = tms ? TAP_EX1IR : TAP_SHIR;
      TAP_EX1IR: nxt = tms ? TAP_UPIR  : TAP_PIR;
      TAP_PIR:   nxt = tms ? TAP_EX2IR : TAP_PIR;
      TAP_EX2IR: nxt = tms ? TAP_UPIR  : TAP_SHIR;
      TAP_UPIR:  nxt = tms ? TAP_SELDR : TAP_IDLE;
      default:   nxt = TAP_RESET;
    endcase
    return nxt;
  endfunction

endpackage

@@ rtl/core/jtt_dp.sv @@
// Datapath: tracked TAP state, TMS shift register, bit counter and result register.
module jtt_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  jtt_pkg::jtt_cmd_t  cmd,
  output jtt_pkg::jtt_stat_t stat,
  input  logic [7:0]         in_tms_bits,
  input  logic [3:0]         in_bit_count,
  input  logic               in_whole_message,
  output logic [3:0]         res_tap_state,
  output logic               res_skipped
);

  jtt_pkg::tap_st_t tap_cur_r, tap_cur_nxt;
  logic [7:0]       bits_r, bits_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             skip_r, skip_nxt;
  logic [3:0]       res_state_r, res_state_nxt;
  logic             res_skip_r, res_skip_nxt;
  logic             quirk;
  logic [3:0]       sat_cnt;

  always_comb begin
    quirk = in_whole_message &&
            (((tap_cur_r == jtt_pkg::TAP_EX1IR) && (in_bit_count == jtt_pkg::QuirkIrCount) &&
              (in_tms_bits == jtt_pkg::QuirkIrBits)) ||
             ((tap_cur_r == jtt_pkg::TAP_EX1DR) && (in_bit_count == jtt_pkg::QuirkDrCount) &&
              (in_tms_bits == jtt_pkg::QuirkDrBits)));
    sat_cnt = (in_bit_count > jtt_pkg::MaxBits) ? jtt_pkg::MaxBits : in_bit_count;
  end

  always_comb begin
    tap_cur_nxt   = tap_cur_r;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    skip_nxt      = skip_r;
    res_state_nxt = res_state_r;
    res_skip_nxt  = res_skip_r;
    if (cmd.load) begin
      bits_nxt = in_tms_bits;
      skip_nxt = quirk;
      // drop the whole beat on a quirk match
      cnt_nxt  = quirk ? 4'd0 : sat_cnt;
    end else if (cmd.step) begin
      tap_cur_nxt = jtt_pkg::tap_next(tap_cur_r, bits_r[0]);
      bits_nxt    = {1'b0, bits_r[7:1]};
      cnt_nxt     = cnt_r - 4'd1;
    end
    if (cmd.push) begin
      res_state_nxt = tap_cur_r;
      res_skip_nxt  = skip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cur_r <= jtt_pkg::TAP_IDLE;
      cnt_r     <= 4'd0;
    end else begin
      tap_cur_r <= tap_cur_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    skip_r      <= skip_nxt;
    res_state_r <= res_state_nxt;
    res_skip_r  <= res_skip_nxt;
  end

  assign stat.done     = (cnt_r == 4'd0);
  assign res_tap_state = res_state_r;
  assign res_skipped   = res_skip_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= jtt_pkg::MaxBits)
    else $error("bit counter out of range");
  a_skip_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && quirk |=> cnt_r == 4'd0)
    else $error("skipped beat still has bits to apply");
  a_skip_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && quirk |=> $stable(tap_cur_r))
    else $error("skipped beat changed the tracked state");
`endif

endmodule

@@ rtl/core/jtt_ctrl.sv @@
// Controller: sequences load, per-bit steps and result push; owns the result valid flag.
module jtt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  jtt_pkg::jtt_stat_t stat,
  output jtt_pkg::jtt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_RUN  = 2'b10
  } ctrl_st_t;

  ctrl_st_t state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        if (!stat.done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_run_until_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_RUN) && !stat.done |=> state_r == C_RUN)
    else $error("left run before all bits applied");
  a_push_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid_r)
    else $error("pushed result not presented");
  a_push_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.done && !cmd.step && !cmd.load)
    else $error("result pushed while bits remain");
`endif

endmodule

@@ rtl/core/jtag_tap_state_tracker.sv @@
// Top level of the JTAG TAP state tracker: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  tms_bits[7:0], bit_count[3:0], whole_message
//   out_     output     out_valid/out_stall  tap_state[3:0], skipped
//
// A beat is loaded, then stepped once per TMS bit through the single next-state
// step for n bits, n the saturated count (0..8), then pushed once the output is free.
// A quirk match or a zero count gives n = 0. The output register frees the input
// side: the next beat is loaded while a result still waits on out_stall.
// Reset (rst_n low, synchronous) puts the tracked state in run-test/idle.
module jtag_tap_state_tracker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_tms_bits,
  input  logic [3:0] in_bit_count,
  input  logic       in_whole_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_tap_state,
  output logic       out_skipped
);

  jtt_pkg::jtt_cmd_t  cmd;
  jtt_pkg::jtt_stat_t stat;

  jtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jtt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_tms_bits      (in_tms_bits),
    .in_bit_count     (in_bit_count),
    .in_whole_message (in_whole_message),
    .res_tap_state    (out_tap_state),
    .res_skipped      (out_skipped)
  );

endmodule

@@ dv/jtag_tap_state_tracker_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the JTAG TAP state tracker: directed and random TMS beats.
module jtag_tap_state_tracker_test;

  typedef struct packed {
    jtt_pkg::tap_st_t state;
    logic             skipped;
  } tap_report_t;

  // Five ones force Test-Logic-Reset from anywhere, then walk toward a shift path.
  localparam logic [7:0] WalkToSelIr = 8'hDF;
  localparam logic [7:0] WalkToCapDr = 8'h5F;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_tms_bits = '0;
  logic [3:0] in_bit_count = '0;
  logic       in_whole_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_tap_state;
  logic       out_skipped;

  jtt_pkg::tap_st_t tracked_state = jtt_pkg::TAP_IDLE;
  tap_report_t      expected_reports[$];
  tap_report_t      oldest_report;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               beats_sent = 0;
  int               reports_checked = 0;
  int               skips_seen = 0;
  int               mismatches = 0;
  int               drain_cycles = 0;
  logic [15:0]      states_reported = '0;

  jtag_tap_state_tracker dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic jtt_pkg::tap_st_t follow_tms(jtt_pkg::tap_st_t cur, logic tms);
    jtt_pkg::tap_st_t nxt;
    nxt = jtt_pkg::TAP_RESET;
    if (tms) begin
      case (cur)
        jtt_pkg::TAP_RESET, jtt_pkg::TAP_SELIR: nxt = jtt_pkg::TAP_RESET;
        jtt_pkg::TAP_IDLE, jtt_pkg::TAP_UPDR, jtt_pkg::TAP_UPIR: nxt = jtt_pkg::TAP_SELDR;
        jtt_pkg::TAP_SELDR:                     nxt = jtt_pkg::TAP_SELIR;
        jtt_pkg::TAP_CAPDR, jtt_pkg::TAP_SHDR:  nxt = jtt_pkg::TAP_EX1DR;
        jtt_pkg::TAP_EX1DR, jtt_pkg::TAP_EX2DR: nxt = jtt_pkg::TAP_UPDR;
        jtt_pkg::TAP_PDR:                       nxt = jtt_pkg::TAP_EX2DR;
        jtt_pkg::TAP_CAPIR, jtt_pkg::TAP_SHIR:  nxt = jtt_pkg::TAP_EX1IR;
        jtt_pkg::TAP_EX1IR, jtt_pkg::TAP_EX2IR: nxt = jtt_pkg::TAP_UPIR;
        jtt_pkg::TAP_PIR:                       nxt = jtt_pkg::TAP_EX2IR;
        default:                                nxt = jtt_pkg::TAP_RESET;
      endcase
    end else begin
      case (cur)
        jtt_pkg::TAP_RESET, jtt_pkg::TAP_IDLE, jtt_pkg::TAP_UPDR, jtt_pkg::TAP_UPIR:
          nxt = jtt_pkg::TAP_IDLE;
        jtt_pkg::TAP_SELDR: nxt = jtt_pkg::TAP_CAPDR;
        jtt_pkg::TAP_CAPDR, jtt_pkg::TAP_SHDR, jtt_pkg::TAP_EX2DR: nxt = jtt_pkg::TAP_SHDR;
        jtt_pkg::TAP_EX1DR, jtt_pkg::TAP_PDR: nxt = jtt_pkg::TAP_PDR;
        jtt_pkg::TAP_SELIR: nxt = jtt_pkg::TAP_CAPIR;
        jtt_pkg::TAP_CAPIR, jtt_pkg::TAP_SHIR, jtt_pkg::TAP_EX2IR: nxt = jtt_pkg::TAP_SHIR;
        jtt_pkg::TAP_EX1IR, jtt_pkg::TAP_PIR: nxt = jtt_pkg::TAP_PIR;
        default:            nxt = jtt_pkg::TAP_RESET;
      endcase
    end
    return nxt;
  endfunction

  function automatic tap_report_t predict_report(logic [7:0] tms, logic [3:0] cnt, logic whole);
    tap_report_t rep;
    int          n;
    rep.skipped = whole &&
                  ((tracked_state == jtt_pkg::TAP_EX1IR && cnt == jtt_pkg::QuirkIrCount &&
                    tms == jtt_pkg::QuirkIrBits) ||
                   (tracked_state == jtt_pkg::TAP_EX1DR && cnt == jtt_pkg::QuirkDrCount &&
                    tms == jtt_pkg::QuirkDrBits));
    if (!rep.skipped) begin
      n = (cnt > jtt_pkg::MaxBits) ? int'(jtt_pkg::MaxBits) : int'(cnt);
      for (int i = 0; i < n; i++) begin
        tracked_state = follow_tms(tracked_state, tms[i]);
      end
    end
    rep.state = tracked_state;
    return rep;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(logic [7:0] tms, logic [3:0] cnt, logic whole);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_tms_bits      <= tms;
    in_bit_count     <= cnt;
    in_whole_message <= whole;
    do @(posedge clk); while (in_stall);
    expected_reports.insert(expected_reports.size(), predict_report(tms, cnt, whole));
    beats_sent++;
  endtask

  // Walk to Exit1 through a shift path, then send the quirk byte or a near miss.
  task automatic send_shift_message();
    logic       for_ir;
    int         exit_at;
    logic [7:0] tms;
    logic [3:0] cnt;
    logic       whole;
    for_ir = 1'($urandom_range(1));
    send_beat(for_ir ? WalkToSelIr : WalkToCapDr, 4'd8, 1'($urandom_range(1)));
    if (for_ir) send_beat(8'h00, 4'd2, 1'($urandom_range(1)));
    repeat ($urandom_range(2)) send_beat(8'h00, 4'($urandom_range(1, 8)), 1'($urandom_range(1)));
    exit_at = int'($urandom_range(7));
    tms = 8'(($urandom() << (exit_at + 1)) | (32'h1 << exit_at));
    send_beat(tms, 4'(exit_at + 1), 1'($urandom_range(1)));
    tms   = for_ir ? jtt_pkg::QuirkIrBits : jtt_pkg::QuirkDrBits;
    cnt   = for_ir ? jtt_pkg::QuirkIrCount : jtt_pkg::QuirkDrCount;
    whole = 1'b1;
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: whole = 1'b0;
        1: cnt = 4'($urandom_range(15));
        2: tms = tms ^ 8'(8'h01 << $urandom_range(7));
        default: begin
          tms = for_ir ? jtt_pkg::QuirkDrBits : jtt_pkg::QuirkIrBits;
          cnt = for_ir ? jtt_pkg::QuirkDrCount : jtt_pkg::QuirkIrCount;
        end
      endcase
    end
    send_beat(tms, cnt, whole);
    if ($urandom_range(3) == 0) send_beat(tms, cnt, whole);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      reports_checked++;
      states_reported[out_tap_state] = 1'b1;
      if (out_skipped) skips_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: state %0d skipped %0b", out_tap_state, out_skipped);
      end else begin
        oldest_report = expected_reports.pop_front();
        if (out_tap_state !== oldest_report.state || out_skipped !== oldest_report.skipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report %0d: expected state %0d skipped %0b, got state %0d skipped %0b",
                     reports_checked, oldest_report.state, oldest_report.skipped,
                     out_tap_state, out_skipped);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_bit_counts();
    send_beat(8'hFF, 4'd0, 1'b0);   // no bits: hold Run-Test/Idle
    send_beat(8'hFF, 4'd15, 1'b1);  // saturate to eight ones
    send_beat(8'h00, 4'd9, 1'b0);
    send_beat(8'hA5, 4'd8, 1'b1);
    send_beat(8'h5A, 4'd1, 1'b0);
  endtask

  task automatic test_shift_self_loops();
    send_beat(WalkToCapDr, 4'd8, 1'b0);
    send_beat(8'h00, 4'd8, 1'b0);
    send_beat(8'h80, 4'd8, 1'b1);
    send_beat(WalkToSelIr, 4'd8, 1'b0);
    send_beat(8'h00, 4'd8, 1'b1);
    send_beat(8'h00, 4'd4, 1'b0);
  endtask

  task automatic test_quirk_filter();
    send_beat(WalkToSelIr, 4'd8, 1'b0);
    send_beat(8'h04, 4'd3, 1'b0);
    send_beat(jtt_pkg::QuirkIrBits, jtt_pkg::QuirkIrCount, 1'b1);
    send_beat(jtt_pkg::QuirkIrBits, jtt_pkg::QuirkIrCount, 1'b1);
    send_beat(jtt_pkg::QuirkIrBits, jtt_pkg::QuirkIrCount, 1'b0);
    // DR byte in Exit1-IR applies and lands in Exit1-DR
    send_beat(jtt_pkg::QuirkDrBits, jtt_pkg::QuirkDrCount, 1'b1);
    send_beat(jtt_pkg::QuirkDrBits, jtt_pkg::QuirkDrCount, 1'b1);
    send_beat(jtt_pkg::QuirkDrBits, 4'd5, 1'b1);
    send_beat(WalkToSelIr, 4'd8, 1'b1);
    send_beat(8'h04, 4'd3, 1'b1);
    send_beat(jtt_pkg::QuirkIrBits ^ 8'h80, jtt_pkg::QuirkIrCount, 1'b1);
  endtask

  task automatic run_traffic(int beats, int idle_pct, int stall_pct);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = beats_sent + beats;
    while (beats_sent < goal) begin
      if ($urandom_range(99) < 60) send_shift_message();
      else send_beat(8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(165, 0, 0);
    run_traffic(165, 52, 0);
    run_traffic(165, 0, 52);
    run_traffic(165, 10, 10);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_bit_counts();
    test_shift_self_loops();
    test_quirk_filter();
    test_random_traffic();
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_reports.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0) begin
      mismatches += expected_reports.size();
      $display("%0d reports never arrived", expected_reports.size());
    end
    $display("%0d beats sent, %0d reports checked, %0d dropped by the shift-message filter",
             beats_sent, reports_checked, skips_seen);
    $display("%0d of 16 TAP states reported, %0d mismatches",
             $countones(states_reported), mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
